// ----- hdl/sads_pkg.sv -----
// ----------------------------------------------------------------------------
// sads_pkg
// shared types and constants of the dual stack on one shared store
// ----------------------------------------------------------------------------
package sads_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned PTR_BITS  = $clog2(DEPTH);
  localparam int unsigned DATA_BITS = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic exec;   // run the accepted item against pointers and store
    logic load;   // move the pending result into the output register
  } sads_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sads_sts_t;

endpackage

// ----- hdl/sads_ram.sv -----
// ----------------------------------------------------------------------------
// sads_ram
// single port ram, one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module sads_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sads_ctrl.sv -----
// ----------------------------------------------------------------------------
// sads_ctrl
// controller: accepts one item, then hands its result to the output register
// ----------------------------------------------------------------------------
module sads_ctrl
  import sads_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sads_sts_t sts_i,
  output sads_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        // wait until the output register is free or being drained
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/sads_dp.sv -----
// ----------------------------------------------------------------------------
// sads_dp
// datapath: top pointers, shared store, pending result and output register
// ----------------------------------------------------------------------------
module sads_dp
  import sads_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sads_cmd_t            cmd_i,
  output sads_sts_t            sts_o,
  input  logic                 opcode_i,
  input  logic                 side_i,
  input  logic [DATA_BITS-1:0] push_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [DATA_BITS-1:0] pop_value_o
);

  localparam logic [PTR_BITS-1:0] RIGHT_BASE = PTR_BITS'(DEPTH - 1);

  logic [PTR_BITS-1:0]  left_q, left_d;
  logic [PTR_BITS-1:0]  right_q, right_d;
  logic [1:0]           pend_status_q;
  logic                 pend_pop_q;
  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [DATA_BITS-1:0] out_data_q;

  logic                 is_pop;
  logic                 is_right;
  logic                 full;
  logic                 empty;
  logic                 ram_we;
  logic                 ram_re;
  logic [PTR_BITS-1:0]  ram_addr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [1:0]           status_d;

  assign is_pop   = (opcode_i == OP_POP);
  assign is_right = (side_i == SIDE_RIGHT);
  assign full     = (left_q >= right_q);
  assign empty    = is_right ? (right_q == RIGHT_BASE) : (left_q == '0);

  always_comb begin
    left_d   = left_q;
    right_d  = right_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = left_q;
    status_d = ST_OK;
    if (!is_pop) begin
      ram_addr = is_right ? right_q : left_q;
      if (full) begin
        status_d = ST_FULL;
      end else begin
        ram_we = cmd_i.exec;
        if (is_right) begin
          right_d = right_q - 1'b1;
        end else begin
          left_d = left_q + 1'b1;
        end
      end
    end else begin
      ram_addr = is_right ? (right_q + 1'b1) : (left_q - 1'b1);
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        ram_re = cmd_i.exec;
        if (is_right) begin
          right_d = right_q + 1'b1;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
    end
  end

  sads_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (WORD_BITS'(push_value_i)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      right_q     <= RIGHT_BASE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        left_q  <= left_d;
        right_q <= right_d;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pend_status_q <= status_d;
      pend_pop_q    <= ram_re;
    end
    if (cmd_i.load) begin
      out_status_q <= pend_status_q;
      // read data holds until the next read, so a stalled load still sees it
      out_data_q   <= pend_pop_q ? DATA_BITS'(ram_rdata) : '0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign pop_value_o    = out_data_q;

endmodule

// ----- hdl/shared_array_dual_stack.sv -----
// ----------------------------------------------------------------------------
// shared_array_dual_stack
// two stacks sharing one store, left growing up and right growing down
// ----------------------------------------------------------------------------
// Each push or pop transfer returns one result transfer. The cycle an item is
// accepted runs the pointer checks and the single store access; the registered
// read data then moves into the output register once that register is free or
// being drained. No new item is taken until the last result has moved into the
// output register. A result waiting in the output register does not block the
// next item from being accepted. Pushes are refused with full status once the
// pointers meet (capacity DEPTH-1 in total); pops on an empty side return empty
// status and a zero word.
module shared_array_dual_stack
  import sads_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_BITS-1:0] s_axis_tdata,   // push_value
  input  logic [1:0]           s_axis_tuser,   // opcode, side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_BITS-1:0] m_axis_tdata,   // pop_value
  output logic [1:0]           m_axis_tuser    // status
);

  sads_cmd_t cmd;
  sads_sts_t sts;

  sads_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sads_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (s_axis_tuser[0]),
    .side_i       (s_axis_tuser[1]),
    .push_value_i (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .pop_value_o  (m_axis_tdata)
  );

endmodule

// ----- test/shared_array_dual_stack_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shared_array_dual_stack_tb
// push/pop checks of the dual stack on one shared store
// ----------------------------------------------------------------------------
// Each accepted push or pop runs through a behavioral copy of the two stacks
// and its status and popped word are queued. Every result transfer is checked
// in order against that queue. Directed items cover empty pops, extreme words
// and pops that carry data. A fill pass drives the pointers together and
// drains both sides. A long receiver hold-off fills the block. Random bursts
// that lean toward growing or shrinking make up the rest, under three idle
// settings on the two streams.
// ----------------------------------------------------------------------------
module shared_array_dual_stack_tb;
  import sads_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int          HOLD_LENGTH    = 300;

  typedef struct {
    status_e              status;
    logic [DATA_BITS-1:0] value;
  } stack_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_BITS-1:0] s_axis_tdata;   // push_value
  logic [1:0]           s_axis_tuser;   // opcode, side
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0] m_axis_tdata;   // pop_value
  logic [1:0]           m_axis_tuser;   // status

  // behavioral copy of the two stacks
  logic [WORD_BITS-1:0] stack_mem [DEPTH];
  logic [PTR_BITS-1:0]  model_left_top;
  logic [PTR_BITS-1:0]  model_right_top;
  stack_result_t        pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_gen      = 0;
  int hold_gen_seen = 0;
  int hold_cycles   = 0;
  int items_sent;
  int results_seen  = 0;
  int full_count;
  int empty_count;
  int error_count   = 0;
  int idle_run      = 0;

  shared_array_dual_stack u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic apply_stack_op(opcode_e op, side_e sd, logic [DATA_BITS-1:0] word);
    stack_result_t r;
    r.status = ST_OK;
    r.value  = '0;
    if (op == OP_PUSH) begin
      if (model_left_top >= model_right_top) begin
        r.status = ST_FULL;
      end else if (sd == SIDE_LEFT) begin
        stack_mem[model_left_top] = word[WORD_BITS-1:0];
        model_left_top = model_left_top + 1'b1;
      end else begin
        stack_mem[model_right_top] = word[WORD_BITS-1:0];
        model_right_top = model_right_top - 1'b1;
      end
    end else if (sd == SIDE_LEFT) begin
      if (model_left_top == '0) begin
        r.status = ST_EMPTY;
      end else begin
        model_left_top = model_left_top - 1'b1;
        r.value = DATA_BITS'(stack_mem[model_left_top]);
      end
    end else begin
      if (model_right_top == PTR_BITS'(DEPTH - 1)) begin
        r.status = ST_EMPTY;
      end else begin
        model_right_top = model_right_top + 1'b1;
        r.value = DATA_BITS'(stack_mem[model_right_top]);
      end
    end
    if (r.status == ST_FULL) full_count++;
    if (r.status == ST_EMPTY) empty_count++;
    pending_results.push_back(r);
  endtask

  // entered just after a rising edge, returns at the edge of the transfer
  task automatic send_item(opcode_e op, side_e sd, logic [DATA_BITS-1:0] word);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {sd, op};
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    apply_stack_op(op, sd, word);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_word();
    logic [DATA_BITS-1:0] w;
    case ($urandom_range(7))
      0: w = 32'h8000_0000;
      1: w = 32'h7fff_ffff;
      2: w = ($urandom_range(1)) ? 32'hffff_ffff : 32'h0000_0000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic test_empty_and_extremes();
    send_item(OP_POP,  SIDE_LEFT,  32'h0000_0000);
    send_item(OP_POP,  SIDE_RIGHT, 32'hffff_ffff);
    send_item(OP_PUSH, SIDE_LEFT,  32'h7fff_ffff);
    send_item(OP_PUSH, SIDE_LEFT,  32'h8000_0000);
    send_item(OP_PUSH, SIDE_RIGHT, 32'h0000_0000);
    send_item(OP_PUSH, SIDE_RIGHT, 32'hffff_ffff);
    send_item(OP_PUSH, SIDE_LEFT,  32'h0000_0001);
    // pops carry junk data that must be ignored
    send_item(OP_POP,  SIDE_LEFT,  32'hdead_beef);
    send_item(OP_POP,  SIDE_LEFT,  32'h5555_5555);
    send_item(OP_POP,  SIDE_RIGHT, 32'haaaa_aaaa);
    send_item(OP_PUSH, SIDE_RIGHT, 32'h1234_5678);
    send_item(OP_POP,  SIDE_LEFT,  32'h0000_0000);
    send_item(OP_POP,  SIDE_LEFT,  32'h0000_0000);
    send_item(OP_POP,  SIDE_RIGHT, 32'h0000_0000);
    send_item(OP_POP,  SIDE_RIGHT, 32'h0000_0000);
    send_item(OP_POP,  SIDE_RIGHT, 32'h0000_0000);
  endtask

  task automatic test_fill_and_drain();
    side_e sd;
    while (model_left_top < model_right_top) begin
      sd = side_e'($urandom_range(1));
      send_item(OP_PUSH, sd, pick_word());
    end
    // pointers meet: pushes on both sides refused
    send_item(OP_PUSH, SIDE_LEFT,  32'hffff_ffff);
    send_item(OP_PUSH, SIDE_RIGHT, 32'h8000_0000);
    send_item(OP_PUSH, SIDE_LEFT,  32'h0000_0000);
    while (model_left_top != '0 || model_right_top != PTR_BITS'(DEPTH - 1)) begin
      if (model_left_top == '0) sd = SIDE_RIGHT;
      else if (model_right_top == PTR_BITS'(DEPTH - 1)) sd = SIDE_LEFT;
      else sd = side_e'($urandom_range(1));
      send_item(OP_POP, sd, $urandom);
    end
    send_item(OP_POP, SIDE_LEFT,  $urandom);
    send_item(OP_POP, SIDE_RIGHT, $urandom);
  endtask

  task automatic test_random_mix(int n_items);
    int sent;
    int burst_len;
    int push_pct;
    int left_pct;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(120, 20);
      case ($urandom_range(3))
        0: push_pct = 85;
        1: push_pct = 20;
        2: push_pct = 55;
        default: push_pct = $urandom_range(100);
      endcase
      left_pct = $urandom_range(100);
      for (int i = 0; i < burst_len && sent < n_items; i++) begin
        send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP,
                  ($urandom_range(99) < left_pct) ? SIDE_LEFT : SIDE_RIGHT,
                  pick_word());
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    // ask the receiver for one long hold-off
    hold_gen++;
    for (int i = 0; i < 30; i++) begin
      send_item(opcode_e'($urandom_range(1)), side_e'($urandom_range(1)), pick_word());
    end
  endtask

  // receiver side: random stalls or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_gen != hold_gen_seen) begin
      hold_gen_seen <= hold_gen;
      m_axis_tready <= 1'b0;
      hold_cycles   <= HOLD_LENGTH - 1;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    stack_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: result transfer with nothing expected: status %0d word %h",
                   m_axis_tuser, m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser !== exp_r.status || m_axis_tdata !== exp_r.value) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result %0d: status exp %0d got %0d, word exp %h got %h",
                     results_seen, exp_r.status, m_axis_tuser, exp_r.value, m_axis_tdata);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    send_idle_pct   = 30;
    recv_idle_pct   = 83;
    items_sent      = 0;
    full_count      = 0;
    empty_count     = 0;
    model_left_top  = '0;
    model_right_top = PTR_BITS'(DEPTH - 1);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_fill_and_drain();
    test_random_mix(370);

    send_idle_pct = 83;
    recv_idle_pct = 30;
    test_random_mix(370);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_mix(370);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d push/pop items, %0d results checked", items_sent, results_seen);
    $display("refused: %0d full pushes, %0d empty pops, %0d mismatches",
             full_count, empty_count, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sads_pkg.sv
hdl/sads_ram.sv
hdl/sads_ctrl.sv
hdl/sads_dp.sv
hdl/shared_array_dual_stack.sv
test/shared_array_dual_stack_tb.sv
